>>> rtl/core/damped_spring_joint_impulse_macros.svh
// Assertion macros shared by the damped spring joint impulse RTL.
`ifndef DAMPED_SPRING_JOINT_IMPULSE_MACROS_SVH
`define DAMPED_SPRING_JOINT_IMPULSE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSJ_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("dsj: same-cycle check failed");
`define DSJ_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("dsj: next-cycle check failed");
`else
`define DSJ_ASSERT_IMPL(label, pre, post)
`define DSJ_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> rtl/core/dsj_pkg.sv
// Types, constants and arithmetic helpers for the damped spring joint impulse.
package dsj_pkg;

    localparam int COMP_W      = 21;
    localparam int NCOMP       = 3;
    localparam int VEC_W       = NCOMP * COMP_W;
    localparam int REL_W       = COMP_W + 1;
    localparam int SQ_W        = 2 * REL_W;
    localparam int ROOT_W      = REL_W;
    localparam int SQRT_PER    = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_PER;
    localparam int COEF_W      = 16;
    localparam int REST_W      = 20;
    localparam int KS_W        = COEF_W + ROOT_W + 2;
    localparam int DSP_W       = COEF_W + ROOT_W;
    localparam int FMAG_W      = 40;
    localparam int FS_W        = FMAG_W + 1;
    localparam int HALF_W      = FMAG_W / 2;
    localparam int QUO_W       = FMAG_W;
    localparam int NUM_W       = REL_W + FMAG_W;
    localparam int PR_W        = REL_W + HALF_W;
    localparam int DIV_PER     = 2;
    localparam int DIV_STAGES  = QUO_W / DIV_PER;
    localparam int PM_W        = HALF_W + COEF_W;
    localparam int SUMP_W      = PM_W + HALF_W;
    localparam int MASS_SHIFT  = 2 * 8;
    localparam int SUM_W       = FS_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = REST_W;

    localparam logic [REST_W-1:0] REST_RESET = REST_W'(1024);
    localparam logic [COEF_W-1:0] K_RESET    = COEF_W'(256);
    localparam logic [COEF_W-1:0] D_RESET    = COEF_W'(0);

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(2 ** (COMP_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REST_LENGTH      = 2'd0,
        CFG_SPRING_STIFFNESS = 2'd1,
        CFG_DAMPING_COEFF    = 2'd2
    } t_cfg_index;

    typedef logic signed [REL_W-1:0] t_rel;

    typedef struct packed {
        logic [VEC_W-1:0]             vel_a;
        logic [VEC_W-1:0]             vel_b;
        logic [COEF_W-1:0]            ma;
        logic [COEF_W-1:0]            mb;
        logic                         dyn_a;
        logic                         dyn_b;
        logic [NCOMP-1:0][REL_W-1:0]  rel;
    } t_carry;

    typedef struct packed {
        logic [SQ_W-1:0]     rad;
        logic [ROOT_W+1:0]   rem;
        logic [ROOT_W-1:0]   root;
    } t_sq;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } t_dv;

    function automatic logic signed [COMP_W-1:0] comp_get(input logic [VEC_W-1:0] v,
                                                          input int idx);
        return v[idx*COMP_W +: COMP_W];
    endfunction

    function automatic logic [REL_W-1:0] mag_rel(input t_rel v);
        logic [REL_W-1:0] u;
        u = v;
        return v[REL_W-1] ? (~u + 1'b1) : u;
    endfunction

    // One root bit per step: bring down two radicand bits and try (root*4 + 1).
    function automatic t_sq sqrt_step(input t_sq s);
        logic [ROOT_W+3:0] tr;
        logic [ROOT_W+3:0] tt;
        logic [ROOT_W+3:0] df;
        t_sq n;
        tr = {s.rem, s.rad[SQ_W-1 -: 2]};
        tt = {2'b00, s.root, 2'b01};
        df = tr - tt;
        n.rad = {s.rad[SQ_W-3:0], 2'b00};
        if (tr >= tt) begin
            n.rem  = df[ROOT_W+1:0];
            n.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            n.rem  = tr[ROOT_W+1:0];
            n.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    function automatic t_sq sqrt_stage(input t_sq s);
        t_sq n;
        n = s;
        for (int j = 0; j < SQRT_PER; j++) begin
            n = sqrt_step(n);
        end
        return n;
    endfunction

    // Restoring division: the numerator's low bits shift out as quotient bits shift in.
    function automatic t_dv div_step(input t_dv s, input logic [ROOT_W-1:0] d);
        logic [ROOT_W:0] tr;
        logic [ROOT_W:0] df;
        logic            qb;
        t_dv n;
        tr = {s.rem, s.quo[QUO_W-1]};
        df = tr - {1'b0, d};
        qb = (tr >= {1'b0, d});
        n.rem = qb ? df[ROOT_W-1:0] : tr[ROOT_W-1:0];
        n.quo = {s.quo[QUO_W-2:0], qb};
        return n;
    endfunction

    function automatic t_dv div_stage(input t_dv s, input logic [ROOT_W-1:0] d);
        t_dv n;
        n = s;
        for (int j = 0; j < DIV_PER; j++) begin
            n = div_step(n, d);
        end
        return n;
    endfunction

    // Returns the clamp flag above the clamped component.
    function automatic logic [COMP_W:0] clamp_comp(input logic signed [SUM_W-1:0] v);
        if (v > SUM_MAX) begin
            return {1'b1, COMP_W'(SUM_MAX)};
        end else if (v < SUM_MIN) begin
            return {1'b1, COMP_W'(SUM_MIN)};
        end
        return {1'b0, v[COMP_W-1:0]};
    endfunction

endpackage

>>> rtl/core/damped_spring_joint_impulse.sv
// Damped spring joint impulse: a 41-stage pipeline taking one joint per unstalled cycle.
//
// A new item may be accepted in every cycle when not stalled, so the block sustains one
// item per cycle. Most of the depth comes from the two square roots (eleven stages, two
// root bits each) and the three impulse dividers (twenty stages, two quotient bits
// each); the remaining stages form the squares, the spring force, the impulse
// numerators and the velocity updates. While a finished result waits at the output the
// whole pipeline holds, and the input is stalled only then. A zero axis length yields a
// zero impulse, and every updated component saturates to 21 bits. The user must write
// configuration only while no item is in flight (not enforced), via a plain write port.
`include "damped_spring_joint_impulse_macros.svh"

module damped_spring_joint_impulse (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dsj_pkg::VEC_W-1:0]        i_pos_a,
    input  logic [dsj_pkg::VEC_W-1:0]        i_pos_b,
    input  logic [dsj_pkg::VEC_W-1:0]        i_vel_a,
    input  logic [dsj_pkg::VEC_W-1:0]        i_vel_b,
    input  logic [dsj_pkg::COEF_W-1:0]       i_inv_mass_a,
    input  logic [dsj_pkg::COEF_W-1:0]       i_inv_mass_b,
    input  logic                             i_a_is_dynamic,
    input  logic                             i_b_is_dynamic,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dsj_pkg::VEC_W-1:0]        o_new_vel_a,
    output logic [dsj_pkg::VEC_W-1:0]        o_new_vel_b,
    output logic                             o_saturated,
    input  logic                             i_cfg_we,
    input  logic [dsj_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dsj_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int NCOMP    = dsj_pkg::NCOMP;
    localparam int ST_SUM   = 2;
    localparam int ST_ROOT  = ST_SUM + dsj_pkg::SQRT_STAGES;
    localparam int ST_NUM   = ST_ROOT + 4;
    localparam int ST_QUO   = ST_NUM + dsj_pkg::DIV_STAGES;
    localparam int ST_OUT   = ST_QUO + 3;
    localparam int NST      = ST_OUT + 1;

    logic en;

    logic [NST-1:0]                      r_vld;
    dsj_pkg::t_carry                     r_cy [ST_OUT];
    dsj_pkg::t_carry                     n_cy;

    logic [dsj_pkg::REST_W-1:0]          r_rest;
    logic [dsj_pkg::COEF_W-1:0]          r_k;
    logic [dsj_pkg::COEF_W-1:0]          r_d;

    dsj_pkg::t_rel                       n_rv  [NCOMP];
    dsj_pkg::t_rel                       r_rv  [NCOMP];
    logic [dsj_pkg::SQ_W-1:0]            n_sqp [NCOMP];
    logic [dsj_pkg::SQ_W-1:0]            n_sqv [NCOMP];
    logic [dsj_pkg::SQ_W-1:0]            r_sqp [NCOMP];
    logic [dsj_pkg::SQ_W-1:0]            r_sqv [NCOMP];
    dsj_pkg::t_sq                        r_sa  [dsj_pkg::SQRT_STAGES+1];
    dsj_pkg::t_sq                        r_sb  [dsj_pkg::SQRT_STAGES+1];

    logic signed [dsj_pkg::ROOT_W:0]     stretch;
    logic signed [dsj_pkg::KS_W-1:0]     r_ks;
    logic [dsj_pkg::DSP_W-1:0]           r_dsp;
    logic [dsj_pkg::ROOT_W-1:0]          r_len_f1;
    logic signed [dsj_pkg::FS_W-1:0]     n_force;
    logic [dsj_pkg::FMAG_W-1:0]          r_fmag;
    logic                                r_fneg;
    logic [dsj_pkg::ROOT_W-1:0]          r_len_f2;

    logic [dsj_pkg::PR_W-1:0]            n_plo [NCOMP];
    logic [dsj_pkg::PR_W-1:0]            n_phi [NCOMP];
    logic [NCOMP-1:0]                    n_psg;
    logic [dsj_pkg::PR_W-1:0]            r_plo [NCOMP];
    logic [dsj_pkg::PR_W-1:0]            r_phi [NCOMP];
    logic [NCOMP-1:0]                    r_psg;
    logic [dsj_pkg::ROOT_W-1:0]          r_len_m1;

    logic [dsj_pkg::NUM_W-1:0]           n_num [NCOMP];
    dsj_pkg::t_dv                        r_dv  [dsj_pkg::DIV_STAGES+1][NCOMP];
    logic [dsj_pkg::ROOT_W-1:0]          r_dlen [dsj_pkg::DIV_STAGES+1];
    logic [NCOMP-1:0]                    r_dsg  [dsj_pkg::DIV_STAGES+1];

    logic [dsj_pkg::QUO_W-1:0]           n_imp [NCOMP];
    logic [dsj_pkg::PM_W-1:0]            r_pa_lo [NCOMP];
    logic [dsj_pkg::PM_W-1:0]            r_pa_hi [NCOMP];
    logic [dsj_pkg::PM_W-1:0]            r_pb_lo [NCOMP];
    logic [dsj_pkg::PM_W-1:0]            r_pb_hi [NCOMP];
    logic [NCOMP-1:0]                    r_vsg;

    logic signed [dsj_pkg::FS_W-1:0]     n_da [NCOMP];
    logic signed [dsj_pkg::FS_W-1:0]     n_db [NCOMP];
    logic signed [dsj_pkg::FS_W-1:0]     r_da [NCOMP];
    logic signed [dsj_pkg::FS_W-1:0]     r_db [NCOMP];

    logic [dsj_pkg::VEC_W-1:0]           n_out_a;
    logic [dsj_pkg::VEC_W-1:0]           n_out_b;
    logic                                n_sat;
    logic [dsj_pkg::VEC_W-1:0]           r_out_a;
    logic [dsj_pkg::VEC_W-1:0]           r_out_b;
    logic                                r_sat;

    // The whole pipeline moves together unless a result is held at the output.
    assign en          = !r_vld[NST-1] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[NST-1];
    assign o_new_vel_a = r_out_a;
    assign o_new_vel_b = r_out_b;
    assign o_saturated = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= dsj_pkg::REST_RESET;
            r_k    <= dsj_pkg::K_RESET;
            r_d    <= dsj_pkg::D_RESET;
        end else if (i_cfg_we) begin
            unique case (dsj_pkg::t_cfg_index'(i_cfg_index))
                dsj_pkg::CFG_REST_LENGTH:      r_rest <= i_cfg_data[dsj_pkg::REST_W-1:0];
                dsj_pkg::CFG_SPRING_STIFFNESS: r_k    <= i_cfg_data[dsj_pkg::COEF_W-1:0];
                dsj_pkg::CFG_DAMPING_COEFF:    r_d    <= i_cfg_data[dsj_pkg::COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // Input stage: relative position and the relative velocity chosen by the dynamic flags.
    always_comb begin
        logic signed [dsj_pkg::COMP_W-1:0] a;
        logic signed [dsj_pkg::COMP_W-1:0] b;
        n_cy.vel_a = i_vel_a;
        n_cy.vel_b = i_vel_b;
        n_cy.ma    = i_inv_mass_a;
        n_cy.mb    = i_inv_mass_b;
        n_cy.dyn_a = i_a_is_dynamic;
        n_cy.dyn_b = i_b_is_dynamic;
        for (int i = 0; i < NCOMP; i++) begin
            n_cy.rel[i] = dsj_pkg::REL_W'(dsj_pkg::comp_get(i_pos_a, i))
                        - dsj_pkg::REL_W'(dsj_pkg::comp_get(i_pos_b, i));
            a = dsj_pkg::comp_get(i_vel_a, i);
            b = dsj_pkg::comp_get(i_vel_b, i);
            priority if (i_a_is_dynamic && i_b_is_dynamic) begin
                n_rv[i] = dsj_pkg::REL_W'(a) - dsj_pkg::REL_W'(b);
            end else if (i_a_is_dynamic) begin
                n_rv[i] = dsj_pkg::REL_W'(a);
            end else if (i_b_is_dynamic) begin
                n_rv[i] = dsj_pkg::REL_W'(b);
            end else begin
                n_rv[i] = '0;
            end
        end
    end

    always_comb begin
        logic [dsj_pkg::REL_W-1:0] mp;
        logic [dsj_pkg::REL_W-1:0] mv;
        for (int i = 0; i < NCOMP; i++) begin
            mp = dsj_pkg::mag_rel(dsj_pkg::t_rel'(r_cy[0].rel[i]));
            mv = dsj_pkg::mag_rel(r_rv[i]);
            n_sqp[i] = mp * mp;
            n_sqv[i] = mv * mv;
        end
    end

    assign stretch = $signed({1'b0, r_sa[dsj_pkg::SQRT_STAGES].root})
                   - $signed({{(dsj_pkg::ROOT_W + 1 - dsj_pkg::REST_W){1'b0}}, r_rest});

    assign n_force = -dsj_pkg::FS_W'(r_ks) - $signed(dsj_pkg::FS_W'(r_dsp));

    always_comb begin
        logic [dsj_pkg::REL_W-1:0] m;
        dsj_pkg::t_rel             rv;
        for (int i = 0; i < NCOMP; i++) begin
            rv       = dsj_pkg::t_rel'(r_cy[ST_ROOT+2].rel[i]);
            m        = dsj_pkg::mag_rel(rv);
            n_plo[i] = m * r_fmag[dsj_pkg::HALF_W-1:0];
            n_phi[i] = m * r_fmag[dsj_pkg::FMAG_W-1:dsj_pkg::HALF_W];
            n_psg[i] = rv[dsj_pkg::REL_W-1] ^ r_fneg;
            n_num[i] = {{(dsj_pkg::NUM_W - dsj_pkg::PR_W){1'b0}}, r_plo[i]}
                     + {r_phi[i], {dsj_pkg::HALF_W{1'b0}}};
        end
    end

    // A zero axis length gives no impulse; the divider output is then ignored.
    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            n_imp[i] = (r_dlen[dsj_pkg::DIV_STAGES] == '0) ? '0
                     : r_dv[dsj_pkg::DIV_STAGES][i].quo;
        end
    end

    always_comb begin
        logic [dsj_pkg::SUMP_W-1:0] sa;
        logic [dsj_pkg::SUMP_W-1:0] sb;
        logic signed [dsj_pkg::FS_W-1:0] ma;
        logic signed [dsj_pkg::FS_W-1:0] mb;
        for (int i = 0; i < NCOMP; i++) begin
            sa = {{dsj_pkg::HALF_W{1'b0}}, r_pa_lo[i]} + {r_pa_hi[i], {dsj_pkg::HALF_W{1'b0}}};
            sb = {{dsj_pkg::HALF_W{1'b0}}, r_pb_lo[i]} + {r_pb_hi[i], {dsj_pkg::HALF_W{1'b0}}};
            ma = $signed({1'b0, sa[dsj_pkg::SUMP_W-1:dsj_pkg::MASS_SHIFT]});
            mb = $signed({1'b0, sb[dsj_pkg::SUMP_W-1:dsj_pkg::MASS_SHIFT]});
            n_da[i] = r_vsg[i] ? -ma : ma;
            n_db[i] = r_vsg[i] ? -mb : mb;
        end
    end

    always_comb begin
        dsj_pkg::t_carry cy;
        logic [dsj_pkg::COMP_W:0] ca;
        logic [dsj_pkg::COMP_W:0] cb;
        cy      = r_cy[ST_OUT-1];
        n_out_a = cy.vel_a;
        n_out_b = cy.vel_b;
        n_sat   = 1'b0;
        for (int i = 0; i < NCOMP; i++) begin
            ca = dsj_pkg::clamp_comp(dsj_pkg::SUM_W'(dsj_pkg::comp_get(cy.vel_a, i))
                                     + dsj_pkg::SUM_W'(r_da[i]));
            cb = dsj_pkg::clamp_comp(dsj_pkg::SUM_W'(dsj_pkg::comp_get(cy.vel_b, i))
                                     - dsj_pkg::SUM_W'(r_db[i]));
            if (cy.dyn_a) begin
                n_out_a[i*dsj_pkg::COMP_W +: dsj_pkg::COMP_W] = ca[dsj_pkg::COMP_W-1:0];
                n_sat = n_sat | ca[dsj_pkg::COMP_W];
            end
            if (cy.dyn_b) begin
                n_out_b[i*dsj_pkg::COMP_W +: dsj_pkg::COMP_W] = cb[dsj_pkg::COMP_W-1:0];
                n_sat = n_sat | cb[dsj_pkg::COMP_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cy[0] <= n_cy;
            for (int k = 1; k < ST_OUT; k++) begin
                r_cy[k] <= r_cy[k-1];
            end
            for (int i = 0; i < NCOMP; i++) begin
                r_rv[i]  <= n_rv[i];
                r_sqp[i] <= n_sqp[i];
                r_sqv[i] <= n_sqv[i];
            end

            r_sa[0].rad  <= r_sqp[0] + r_sqp[1] + r_sqp[2];
            r_sa[0].rem  <= '0;
            r_sa[0].root <= '0;
            r_sb[0].rad  <= r_sqv[0] + r_sqv[1] + r_sqv[2];
            r_sb[0].rem  <= '0;
            r_sb[0].root <= '0;
            for (int k = 1; k <= dsj_pkg::SQRT_STAGES; k++) begin
                r_sa[k] <= dsj_pkg::sqrt_stage(r_sa[k-1]);
                r_sb[k] <= dsj_pkg::sqrt_stage(r_sb[k-1]);
            end

            // Force is kept with eight extra fraction bits, as magnitude and sign.
            r_ks     <= $signed({1'b0, r_k}) * stretch;
            r_dsp    <= r_d * r_sb[dsj_pkg::SQRT_STAGES].root;
            r_len_f1 <= r_sa[dsj_pkg::SQRT_STAGES].root;
            r_fneg   <= n_force[dsj_pkg::FS_W-1];
            r_fmag   <= n_force[dsj_pkg::FS_W-1] ? dsj_pkg::FMAG_W'(-n_force)
                                                 : dsj_pkg::FMAG_W'(n_force);
            r_len_f2 <= r_len_f1;

            for (int i = 0; i < NCOMP; i++) begin
                r_plo[i] <= n_plo[i];
                r_phi[i] <= n_phi[i];
                r_dv[0][i].rem <= n_num[i][dsj_pkg::NUM_W-1:dsj_pkg::QUO_W];
                r_dv[0][i].quo <= n_num[i][dsj_pkg::QUO_W-1:0];
            end
            r_psg     <= n_psg;
            r_len_m1  <= r_len_f2;
            r_dlen[0] <= r_len_m1;
            r_dsg[0]  <= r_psg;
            for (int k = 1; k <= dsj_pkg::DIV_STAGES; k++) begin
                for (int i = 0; i < NCOMP; i++) begin
                    r_dv[k][i] <= dsj_pkg::div_stage(r_dv[k-1][i], r_dlen[k-1]);
                end
                r_dlen[k] <= r_dlen[k-1];
                r_dsg[k]  <= r_dsg[k-1];
            end

            for (int i = 0; i < NCOMP; i++) begin
                r_pa_lo[i] <= n_imp[i][dsj_pkg::HALF_W-1:0] * r_cy[ST_QUO].ma;
                r_pa_hi[i] <= n_imp[i][dsj_pkg::QUO_W-1:dsj_pkg::HALF_W] * r_cy[ST_QUO].ma;
                r_pb_lo[i] <= n_imp[i][dsj_pkg::HALF_W-1:0] * r_cy[ST_QUO].mb;
                r_pb_hi[i] <= n_imp[i][dsj_pkg::QUO_W-1:dsj_pkg::HALF_W] * r_cy[ST_QUO].mb;
                r_da[i]    <= n_da[i];
                r_db[i]    <= n_db[i];
            end
            r_vsg <= r_dsg[dsj_pkg::DIV_STAGES];

            r_out_a <= n_out_a;
            r_out_b <= n_out_b;
            r_sat   <= n_sat;
        end
    end

    `DSJ_ASSERT_IMPL(a_hold_stalls_input, r_vld[NST-1] && i_out_stall, o_in_stall)
    `DSJ_ASSERT_NEXT(a_frozen_valids, o_in_stall, $stable(r_vld))
    `DSJ_ASSERT_NEXT(a_last_stage_fills, !o_in_stall && r_vld[NST-2], o_out_valid)

endmodule
